### hw/rtl/wlpm_pkg.sv
// Shared constants and types of the window/level pseudo-color mapper.
// No dependencies; every other file imports this package.
`default_nettype none

package wlpm_pkg;

  localparam int KEY_BITS     = 16;
  localparam int CHAN_BITS    = 8;
  localparam int NUM_BITS     = KEY_BITS + CHAN_BITS;
  localparam int DIV_STEPS    = CHAN_BITS;
  localparam int DIFF_BITS    = KEY_BITS + 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PSEUDO = 2'd2;

  localparam logic [KEY_BITS-1:0] WIDTH_RST = 16'd4095;
  localparam logic [KEY_BITS-1:0] LEVEL_RST = 16'd2048;

  localparam logic [1:0] CLS_BLACK = 2'd0;
  localparam logic [1:0] CLS_OVER  = 2'd1;
  localparam logic [1:0] CLS_RAMP  = 2'd2;

  typedef struct packed {
    logic [1:0] cls;
    logic       pseudo;
  } side_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

### hw/rtl/wlpm_if.sv
// Channel interfaces of the window/level pseudo-color mapper: pixel input,
// color output and register write. Depends on wlpm_pkg.
`default_nettype none

interface wlpm_in_if import wlpm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] pixel_key;
  modport source (output valid, output pixel_key, input ready);
  modport sink (input valid, input pixel_key, output ready);
endinterface

interface wlpm_out_if import wlpm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAN_BITS-1:0] red;
  logic [CHAN_BITS-1:0] green;
  logic [CHAN_BITS-1:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface wlpm_cfg_if import wlpm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [KEY_BITS-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/wlpm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient is known to fit CHAN_BITS bits. Depends on wlpm_pkg.
`default_nettype none

module wlpm_div import wlpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [NUM_BITS-1:0]  up_num,
  input  logic [KEY_BITS-1:0]  up_den,
  input  side_t                up_side,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [CHAN_BITS-1:0] dn_quo,
  output side_t                dn_side
);

  logic [DIV_STEPS-1:0] vld_r;
  logic [NUM_BITS-1:0]  rem_r  [DIV_STEPS];
  logic [KEY_BITS-1:0]  den_r  [DIV_STEPS];
  logic [CHAN_BITS-1:0] quo_r  [DIV_STEPS];
  side_t                side_r [DIV_STEPS];
  logic [DIV_STEPS:0]   rdy;

  assign rdy[DIV_STEPS] = dn_ready;
  assign up_ready       = rdy[0];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic                 vld_in;
    logic [NUM_BITS-1:0]  rem_in;
    logic [KEY_BITS-1:0]  den_in;
    logic [CHAN_BITS-1:0] quo_in;
    side_t                side_in;
    logic [NUM_BITS-1:0]  dsh;
    logic                 take;
    logic [NUM_BITS-1:0]  rem_nxt;
    logic [CHAN_BITS-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = up_valid;
      assign rem_in  = up_num;
      assign den_in  = up_den;
      assign quo_in  = '0;
      assign side_in = up_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign dsh  = NUM_BITS'(den_in) << (DIV_STEPS - 1 - s);
    assign take = (rem_in >= dsh);

    always_comb begin
      rem_nxt = take ? (rem_in - dsh) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[DIV_STEPS-1-s] = take;
    end

    assign rdy[s] = !vld_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld_in) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_in;
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign dn_valid = vld_r[DIV_STEPS-1];
  assign dn_quo   = quo_r[DIV_STEPS-1];
  assign dn_side  = side_r[DIV_STEPS-1];

endmodule

`default_nettype wire

### hw/rtl/window_level_pseudocolor_map.sv
// Window/level mapper: 16-bit pixel key to grey or pseudo-color RGB.
// Stages from input transaction to output valid: window compare, scale by 255,
// 8 divider steps, color lookup. Throughput: one pixel per cycle unless stalled.
// A stalled output holds only the stages behind it; bubbles are squeezed out.
// Reset (synchronous, active low): pipeline empty, width 4095, level 2048, grey.
// Depends on wlpm_pkg, wlpm_if and wlpm_div.
`default_nettype none

module window_level_pseudocolor_map import wlpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wlpm_in_if.sink    in_if,
  wlpm_out_if.source out_if,
  wlpm_cfg_if.sink   cfg_if
);

  localparam logic [7:0] GREY_TOP  = 8'd200;
  localparam logic [7:0] PINK_TOP  = 8'd220;
  localparam logic [7:0] YEL_TOP   = 8'd240;
  localparam logic [7:0] PINK_BASE = 8'd201;
  localparam logic [7:0] YEL_BASE  = 8'd221;
  localparam logic [7:0] BLUE_BASE = 8'd241;
  localparam logic [7:0] BLUE_LAST = 8'd9;

  localparam logic [7:0] PINK_RB [0:19] = '{
    8'd200, 8'd202, 8'd205, 8'd208, 8'd211, 8'd214, 8'd217, 8'd220, 8'd223, 8'd226,
    8'd228, 8'd231, 8'd234, 8'd237, 8'd240, 8'd243, 8'd246, 8'd249, 8'd252, 8'd255};
  localparam logic [7:0] PINK_G [0:19] = '{
    8'd200, 8'd189, 8'd178, 8'd168, 8'd157, 8'd147, 8'd136, 8'd126, 8'd115, 8'd105,
    8'd94,  8'd84,  8'd73,  8'd63,  8'd52,  8'd42,  8'd31,  8'd21,  8'd10,  8'd0};
  localparam logic [7:0] YEL_G [0:19] = '{
    8'd0,   8'd13,  8'd26,  8'd40,  8'd53,  8'd67,  8'd80,  8'd93,  8'd107, 8'd120,
    8'd134, 8'd147, 8'd161, 8'd174, 8'd187, 8'd201, 8'd214, 8'd228, 8'd241, 8'd255};
  localparam logic [7:0] YEL_B [0:19] = '{
    8'd255, 8'd241, 8'd228, 8'd214, 8'd201, 8'd187, 8'd174, 8'd161, 8'd147, 8'd134,
    8'd120, 8'd107, 8'd93,  8'd80,  8'd67,  8'd53,  8'd40,  8'd26,  8'd13,  8'd0};
  localparam logic [7:0] BLUE_RG [0:9] = '{
    8'd255, 8'd226, 8'd198, 8'd170, 8'd141, 8'd113, 8'd85, 8'd56, 8'd28, 8'd0};
  localparam logic [7:0] BLUE_B [0:9] = '{
    8'd0, 8'd28, 8'd56, 8'd85, 8'd113, 8'd141, 8'd170, 8'd198, 8'd226, 8'd255};

  function automatic rgb_t map_color(side_t side, logic [CHAN_BITS-1:0] v);
    rgb_t       c;
    logic [7:0] t;
    logic [4:0] t20;
    logic [3:0] t10;
    t   = 8'd0;
    t20 = 5'd0;
    t10 = 4'd0;
    c   = '0;
    case (side.cls)
      CLS_BLACK: begin
        c = '0;
      end
      CLS_OVER: begin
        c.blue  = 8'hFF;
        c.red   = side.pseudo ? 8'h00 : 8'hFF;
        c.green = side.pseudo ? 8'h00 : 8'hFF;
      end
      CLS_RAMP: begin
        if (!side.pseudo || v <= GREY_TOP) begin
          c = '{red: v, green: v, blue: v};
        end else if (v <= PINK_TOP) begin
          t   = v - PINK_BASE;
          t20 = t[4:0];
          c   = '{red: PINK_RB[t20], green: PINK_G[t20], blue: PINK_RB[t20]};
        end else if (v <= YEL_TOP) begin
          t   = v - YEL_BASE;
          t20 = t[4:0];
          c   = '{red: 8'hFF, green: YEL_G[t20], blue: YEL_B[t20]};
        end else begin
          t   = v - BLUE_BASE;
          t10 = (t > BLUE_LAST) ? BLUE_LAST[3:0] : t[3:0];
          c   = '{red: BLUE_RG[t10], green: BLUE_RG[t10], blue: BLUE_B[t10]};
        end
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

  logic [KEY_BITS-1:0] width_r;
  logic [KEY_BITS-1:0] level_r;
  logic                pseudo_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      level_r  <= LEVEL_RST;
      pseudo_r <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_WIDTH:  width_r  <= cfg_if.data;
        REG_LEVEL:  level_r  <= cfg_if.data;
        REG_PSEUDO: pseudo_r <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // window: low = level - floor((w-1)/2), high - low = w - 1
  logic [KEY_BITS-1:0]         w_eff;
  logic [KEY_BITS-1:0]         span;
  logic signed [DIFF_BITS-1:0] low;
  logic signed [DIFF_BITS-1:0] diff;
  logic [1:0]                  cls_nxt;

  always_comb begin
    w_eff = (width_r == '0) ? KEY_BITS'(1) : width_r;
    span  = w_eff - KEY_BITS'(1);
    low   = $signed({2'b00, level_r}) - $signed({3'b000, span[KEY_BITS-1:1]});
    diff  = $signed({2'b00, in_if.pixel_key}) - low;
    if (diff <= $signed(DIFF_BITS'(0))) begin
      cls_nxt = CLS_BLACK;
    end else if (diff > $signed({2'b00, span})) begin
      cls_nxt = CLS_OVER;
    end else begin
      cls_nxt = CLS_RAMP;
    end
  end

  logic                 a_vld_r;
  logic [KEY_BITS-1:0]  a_diff_r;
  logic [KEY_BITS-1:0]  a_den_r;
  side_t                a_side_r;
  logic                 a_rdy;

  logic                 b_vld_r;
  logic [NUM_BITS-1:0]  b_num_r;
  logic [KEY_BITS-1:0]  b_den_r;
  side_t                b_side_r;
  logic                 b_rdy;

  logic                 div_up_ready;
  logic                 div_valid;
  logic [CHAN_BITS-1:0] div_quo;
  side_t                div_side;
  logic                 out_rdy;

  logic                 out_valid_r;
  rgb_t                 out_rgb_r;

  assign out_rdy     = !out_valid_r || out_if.ready;
  assign b_rdy       = !b_vld_r || div_up_ready;
  assign a_rdy       = !a_vld_r || b_rdy;
  assign in_if.ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= in_if.valid;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_if.valid) begin
      a_diff_r <= diff[KEY_BITS-1:0];
      a_den_r  <= span;
      a_side_r <= '{cls: cls_nxt, pseudo: pseudo_r};
    end
    if (b_rdy && a_vld_r) begin
      b_num_r  <= {a_diff_r, {CHAN_BITS{1'b0}}} - NUM_BITS'(a_diff_r);
      b_den_r  <= a_den_r;
      b_side_r <= a_side_r;
    end
  end

  wlpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_vld_r),
    .up_ready (div_up_ready),
    .up_num   (b_num_r),
    .up_den   (b_den_r),
    .up_side  (b_side_r),
    .dn_valid (div_valid),
    .dn_ready (out_rdy),
    .dn_quo   (div_quo),
    .dn_side  (div_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div_valid) begin
      out_rgb_r <= map_color(div_side, div_quo);
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.red   = out_rgb_r.red;
  assign out_if.green = out_rgb_r.green;
  assign out_if.blue  = out_rgb_r.blue;

endmodule

`default_nettype wire

### verif/wlpm_color_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the window/level mapper: watches the pixel, color and register
// channels, predicts every color from its own copy of the registers and compares in order.
// Depends on wlpm_pkg and the channel interfaces of wlpm_if.
module wlpm_color_checker import wlpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  wlpm_in_if   in_ch,
  wlpm_out_if  out_ch,
  wlpm_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [KEY_BITS-1:0] key;
    rgb_t                color;
  } pixel_expect_t;

  logic [KEY_BITS-1:0] win_width;
  logic [KEY_BITS-1:0] win_level;
  logic                pseudo_on;
  pixel_expect_t       expected_colors[$];

  function automatic rgb_t make_rgb(int r, int g, int b);
    rgb_t c;
    c.red   = r[CHAN_BITS-1:0];
    c.green = g[CHAN_BITS-1:0];
    c.blue  = b[CHAN_BITS-1:0];
    return c;
  endfunction

  function automatic rgb_t tint_level(int v);
    int t;
    if (v <= 200) begin
      return make_rgb(v, v, v);
    end else if (v <= 220) begin
      t = v - 201;
      return make_rgb(200 + (55 * t) / 19, 200 - (200 * t + 18) / 19, 200 + (55 * t) / 19);
    end else if (v <= 240) begin
      t = v - 221;
      return make_rgb(255, (255 * t) / 19, 255 - (255 * t + 18) / 19);
    end
    t = v - 241;
    if (t > 9) begin
      t = 9;
    end
    return make_rgb(255 - (255 * t + 8) / 9, 255 - (255 * t + 8) / 9, (255 * t) / 9);
  endfunction

  function automatic rgb_t map_pixel(logic [KEY_BITS-1:0] key);
    int w;
    int lvl;
    int lo;
    int hi;
    int k;
    int v;
    w   = (win_width == '0) ? 1 : int'(win_width);
    lvl = int'(win_level);
    k   = int'(key);
    lo  = lvl - (w - 1) / 2;
    hi  = lvl + w / 2;
    if (k <= lo) begin
      return make_rgb(0, 0, 0);
    end else if (k > hi) begin
      return pseudo_on ? make_rgb(0, 0, 255) : make_rgb(255, 255, 255);
    end
    v = ((k - lo) * 255) / (hi - lo);
    return pseudo_on ? tint_level(v) : make_rgb(v, v, v);
  endfunction

  always @(posedge clk) begin
    pixel_expect_t exp_item;
    pixel_expect_t new_item;
    if (!rst_n) begin
      win_width  <= WIDTH_RST;
      win_level  <= LEVEL_RST;
      pseudo_on  <= 1'b0;
      fail_count <= 0;
      pending    <= 0;
      expected_colors.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_WIDTH:  win_width <= cfg_ch.data;
          REG_LEVEL:  win_level <= cfg_ch.data;
          REG_PSEUDO: pseudo_on <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_colors.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected color transaction r=%0d g=%0d b=%0d",
                     out_ch.red, out_ch.green, out_ch.blue);
          end
          fail_count <= fail_count + 1;
        end else begin
          exp_item = expected_colors.pop_front();
          if (out_ch.red !== exp_item.color.red || out_ch.green !== exp_item.color.green ||
              out_ch.blue !== exp_item.color.blue) begin
            if (fail_count < 10) begin
              $display("key %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       exp_item.key, exp_item.color.red, exp_item.color.green,
                       exp_item.color.blue, out_ch.red, out_ch.green, out_ch.blue);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        new_item.key   = in_ch.pixel_key;
        new_item.color = map_pixel(in_ch.pixel_key);
        expected_colors.push_back(new_item);
      end
      pending <= expected_colors.size();
    end
  end

endmodule

### verif/window_level_pseudocolor_map_tb.sv
`timescale 1ns / 1ps
// Top of the window/level mapper testbench: clock, reset, register and pixel stimulus,
// output stalls, watchdog and verdict. Depends on wlpm_pkg, wlpm_if, the mapper and
// wlpm_color_checker.
module window_level_pseudocolor_map_tb;
  import wlpm_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int PIPE_LATENCY   = 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1350;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                no_idle;
  logic [KEY_BITS-1:0] cur_width;
  logic [KEY_BITS-1:0] cur_level;
  int                  stall_left;
  int                  idle_cycles;
  int                  fail_count;
  int                  pending;
  int                  random_sent;

  wlpm_in_if  pixel_ch();
  wlpm_out_if color_ch();
  wlpm_cfg_if cfg_ch();

  window_level_pseudocolor_map dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pixel_ch),
    .out_if (color_ch),
    .cfg_if (cfg_ch)
  );

  wlpm_color_checker color_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (pixel_ch),
    .out_ch     (color_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      color_ch.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left > 0) begin
      color_ch.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else begin
      color_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        stall_left <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((pixel_ch.valid && pixel_ch.ready) || (color_ch.valid && color_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("window_level_pseudocolor_map: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [KEY_BITS-1:0] key);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid     <= 1'b1;
    pixel_ch.pixel_key <= key;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [KEY_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_WIDTH) begin
      cur_width = data;
    end else if (idx == REG_LEVEL) begin
      cur_level = data;
    end
  endtask

  task automatic drain();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_window(input logic [KEY_BITS-1:0] width, input logic [KEY_BITS-1:0] level,
                            input logic [KEY_BITS-1:0] pseudo, input bit spare);
    drain();
    write_reg(REG_WIDTH, width);
    if (spare) begin
      write_reg(REG_SPARE, KEY_BITS'($urandom_range(0, 65535)));
    end
    write_reg(REG_LEVEL, level);
    write_reg(REG_PSEUDO, pseudo);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    int w;
    int lvl;
    int half;
    int k;
    w    = (cur_width == '0) ? 1 : int'(cur_width);
    lvl  = int'(cur_level);
    half = w / 2 + 2;
    r    = $urandom_range(0, 99);
    if (r < 65) begin
      k = lvl + int'($urandom_range(0, 2 * half)) - half;
    end else if (r < 80) begin
      k = lvl - (w - 1) / 2 + int'($urandom_range(0, 2)) - 1;
    end else if (r < 90) begin
      k = lvl + w / 2 + int'($urandom_range(0, 2)) - 1;
    end else if (r < 95) begin
      k = $urandom_range(0, 1) ? 65535 : 0;
    end else begin
      k = $urandom_range(0, 65535);
    end
    if (k < 0) begin
      k = 0;
    end else if (k > 65535) begin
      k = 65535;
    end
    return k[KEY_BITS-1:0];
  endfunction

  initial begin
    int count;
    int sel;
    logic [KEY_BITS-1:0] width;
    logic [KEY_BITS-1:0] level;
    rst_n              = 1'b0;
    no_idle            = 1'b0;
    random_sent        = 0;
    cur_width          = WIDTH_RST;
    cur_level          = LEVEL_RST;
    pixel_ch.valid     = 1'b0;
    pixel_ch.pixel_key = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_WIDTH;
    cfg_ch.data        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset window: edges at 1 and 4095, grey
    send_pixel(16'd0);
    send_pixel(16'd65535);
    send_pixel(16'd1);
    send_pixel(16'd2);
    send_pixel(16'd2048);
    send_pixel(16'd4095);
    send_pixel(16'd4096);

    // single-wide window: level is black, one above is over range
    set_window(16'd1, 16'd100, 16'd1, 1'b0);
    send_pixel(16'd100);
    send_pixel(16'd101);
    send_pixel(16'd99);

    // zero width behaves as one, window at the top of the key range
    set_window(16'd0, 16'd65535, 16'hFFFE, 1'b1);
    send_pixel(16'd65535);
    send_pixel(16'd65534);
    send_pixel(16'd0);

    // widest window hanging below zero, every pseudo-color ramp
    set_window(16'd65535, 16'd0, 16'd1, 1'b0);
    send_pixel(16'd0);
    send_pixel(16'd20000);
    send_pixel(16'd25000);
    send_pixel(16'd30000);
    send_pixel(16'd32700);
    send_pixel(16'd32767);
    send_pixel(16'd32768);
    send_pixel(16'd65535);

    // widest window hanging above the key range
    set_window(16'd65535, 16'd65535, 16'd0, 1'b0);
    send_pixel(16'd65535);
    send_pixel(16'd0);
    send_pixel(16'd40000);

    while (random_sent < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: width = KEY_BITS'($urandom_range(0, 4));
        1: width = $urandom_range(0, 1) ? 16'd65535 : 16'd65534;
        2: width = KEY_BITS'($urandom_range(5, 300));
        default: width = KEY_BITS'($urandom_range(0, 65535));
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        level = 16'd0;
      end else if (sel < 30) begin
        level = 16'd65535;
      end else begin
        level = KEY_BITS'($urandom_range(0, 65535));
      end
      set_window(width, level, KEY_BITS'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 4) == 0);
      count   = $urandom_range(5, 80);
      repeat (count) begin
        send_pixel(pick_key());
        random_sent++;
      end
    end

    drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("window_level_pseudocolor_map: match");
    end else begin
      $display("window_level_pseudocolor_map: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/wlpm_pkg.sv
hw/rtl/wlpm_if.sv
hw/rtl/wlpm_div.sv
hw/rtl/window_level_pseudocolor_map.sv
verif/wlpm_color_checker.sv
verif/window_level_pseudocolor_map_tb.sv
